>>> rtl/mbrx_pkg.sv
`timescale 1ns / 1ps

package mbrx_pkg;

  // longest frame the index can track before it wraps
  localparam int FrameMax  = 256;
  localparam int IdxW      = $clog2(FrameMax);

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [7:0] CodeRead      = 8'd3;
  localparam logic [7:0] CodeWriteOne  = 8'd6;
  localparam logic [7:0] CodeWriteMany = 8'd16;

  // byte positions inside the request
  localparam int IdxSlave  = 0;
  localparam int IdxFunc   = 1;
  localparam int IdxAddrHi = 2;
  localparam int IdxAddrLo = 3;
  localparam int IdxQtyHi  = 4;
  localparam int IdxQtyLo  = 5;
  localparam int IdxCount  = 6;
  localparam int ShortLast = 7;
  localparam int ManyExtra = 8;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_CRC  = 2'd1,
    ERR_CMD  = 2'd2
  } err_e;

  // register map, byte address is 4 * index
  localparam logic [2:0] AddrSlave = 3'd0;
  localparam logic [2:0] AddrFlash = 3'd4;

  typedef struct packed {
    logic [7:0]  function_code;
    logic        is_broadcast;
    logic [15:0] start_address;
    logic [15:0] quantity_or_value;
    logic [7:0]  frame_length;
    err_e        error_code;
    logic        flash_update_request;
  } rslt_t;

  // one byte through the reflected crc-16, lsb first
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/mbrx_deframer.sv
`timescale 1ns / 1ps

module mbrx_deframer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_vld_i,
  input  logic [7:0]        byte_i,
  input  logic [7:0]        slave_addr_i,
  input  logic [15:0]       flash_addr_i,
  output logic              done_o,
  output mbrx_pkg::rslt_t   rslt_o
);

  localparam int IdxW = mbrx_pkg::IdxW;

  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      func_q, func_d;
  logic [15:0]     crc_q, crc_d;
  logic [15:0]     addr_q, addr_d;
  logic [15:0]     qty_q, qty_d;
  logic [7:0]      cnt_q, cnt_d;
  logic            bcast_q, bcast_d;

  logic [15:0]     crc_in, crc_new;
  logic [IdxW:0]   idx_inc;
  logic [8:0]      idx_ext, many_end, len_full;
  logic            code_ok, addr_ok;

  assign crc_in   = (idx_q == IdxW'(mbrx_pkg::IdxSlave)) ? mbrx_pkg::CrcInit : crc_q;
  assign crc_new  = mbrx_pkg::crc_fold(crc_in, byte_i);
  assign idx_inc  = (IdxW + 1)'(idx_q) + (IdxW + 1)'(1);
  assign idx_ext  = 9'(idx_q);
  assign many_end = 9'(cnt_d) + 9'(mbrx_pkg::ManyExtra);
  assign len_full = idx_ext + 9'd1;
  assign code_ok  = (byte_i == mbrx_pkg::CodeRead) || (byte_i == mbrx_pkg::CodeWriteOne) ||
                    (byte_i == mbrx_pkg::CodeWriteMany);
  assign addr_ok  = (byte_i == slave_addr_i) || (byte_i == 8'd0);

  always_comb begin
    idx_d   = idx_q;
    func_d  = func_q;
    crc_d   = crc_q;
    addr_d  = addr_q;
    qty_d   = qty_q;
    cnt_d   = cnt_q;
    bcast_d = bcast_q;
    done_o  = 1'b0;

    if (byte_vld_i) begin
      if (idx_q == IdxW'(mbrx_pkg::IdxSlave)) begin
        // foreign station bytes are dropped silently
        if (addr_ok) begin
          bcast_d = (byte_i == 8'd0);
          crc_d   = crc_new;
          idx_d   = IdxW'(mbrx_pkg::IdxFunc);
        end
      end else if (idx_q == IdxW'(mbrx_pkg::IdxFunc)) begin
        if (code_ok) begin
          func_d = byte_i;
          crc_d  = crc_new;
          idx_d  = IdxW'(mbrx_pkg::IdxAddrHi);
        end else begin
          idx_d = '0;
          crc_d = mbrx_pkg::CrcInit;
        end
      end else begin
        crc_d = crc_new;
        if (idx_q == IdxW'(mbrx_pkg::IdxAddrHi)) addr_d[15:8] = byte_i;
        if (idx_q == IdxW'(mbrx_pkg::IdxAddrLo)) addr_d[7:0]  = byte_i;
        if (idx_q == IdxW'(mbrx_pkg::IdxQtyHi))  qty_d[15:8]  = byte_i;
        if (idx_q == IdxW'(mbrx_pkg::IdxQtyLo))  qty_d[7:0]   = byte_i;
        if (idx_q == IdxW'(mbrx_pkg::IdxCount))  cnt_d        = byte_i;

        if (idx_q != IdxW'(mbrx_pkg::IdxAddrHi)) begin
          if (func_q == mbrx_pkg::CodeWriteMany) begin
            done_o = (idx_ext >= 9'(mbrx_pkg::ShortLast)) && (idx_ext == many_end);
          end else begin
            done_o = (idx_q == IdxW'(mbrx_pkg::ShortLast));
          end
        end

        if (done_o || (idx_inc >= (IdxW + 1)'(mbrx_pkg::FrameMax))) begin
          idx_d = '0;
          crc_d = mbrx_pkg::CrcInit;
        end else begin
          idx_d = idx_inc[IdxW-1:0];
        end
      end
    end
  end

  always_comb begin
    rslt_o.function_code        = func_q;
    rslt_o.is_broadcast         = bcast_q;
    rslt_o.start_address        = addr_d;
    rslt_o.quantity_or_value    = qty_d;
    rslt_o.frame_length         = len_full[8] ? 8'hFF : len_full[7:0];
    rslt_o.error_code           = mbrx_pkg::ERR_NONE;
    rslt_o.flash_update_request = 1'b0;
    if (crc_new != 16'h0000) begin
      rslt_o.error_code = mbrx_pkg::ERR_CRC;
    end else if (func_q == mbrx_pkg::CodeWriteMany) begin
      if ((addr_d == flash_addr_i) && (qty_d == 16'd1)) begin
        rslt_o.flash_update_request = 1'b1;
      end else begin
        rslt_o.error_code = mbrx_pkg::ERR_CMD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      func_q  <= mbrx_pkg::CodeRead;
      crc_q   <= mbrx_pkg::CrcInit;
      addr_q  <= '0;
      qty_q   <= '0;
      cnt_q   <= '0;
      bcast_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      func_q  <= func_d;
      crc_q   <= crc_d;
      addr_q  <= addr_d;
      qty_q   <= qty_d;
      cnt_q   <= cnt_d;
      bcast_q <= bcast_d;
    end
  end

endmodule

>>> rtl/modbus_rtu_slave_frame_receiver.sv
`timescale 1ns / 1ps

// modbus rtu slave request deframer: takes one received serial byte per
// cycle on the slave stream, filters frames for the own station address (or
// broadcast 0) with function code 3, 6 or 16, runs the modbus crc-16 over the
// whole frame and sends one result per completed frame on the master stream.
// a byte goes through an input register, then the frame tracker and crc
// update (one unrolled byte step) into the result register, and a new byte
// is taken every cycle as long as the result register is free or being
// drained; only a result held back by the sink stalls input.
// config registers (apb): 0x0 slave_address, 0x4 flash_connect_address;
// write them only while no frame is in flight.

module modbus_rtu_slave_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request bytes in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // frame results out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] function_code, [23:8] start_address, [39:24] quantity_or_value,
  // [47:40] frame_length, [49:48] error_code, [50] flash_update_request
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] is_broadcast
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // config registers
  logic [7:0]  slave_addr_q;
  logic [15:0] flash_addr_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= 8'd1;
      flash_addr_q <= 16'd0;
    end else if (cfg_wr) begin
      // decode on the word bit only, low address bits are ignored
      if (paddr[2] == mbrx_pkg::AddrFlash[2]) begin
        flash_addr_q <= pwdata[15:0];
      end else begin
        slave_addr_q <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == mbrx_pkg::AddrFlash[2]) begin
      prdata = {16'd0, flash_addr_q};
    end else begin
      prdata = {24'd0, slave_addr_q};
    end
  end

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       advance;

  // the tracked byte moves on when the result slot is free or draining
  assign advance       = in_vld_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // frame tracker and crc
  logic            frame_done;
  mbrx_pkg::rslt_t rslt;

  mbrx_deframer u_deframer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_vld_i   (advance),
    .byte_i       (in_byte_q),
    .slave_addr_i (slave_addr_q),
    .flash_addr_i (flash_addr_q),
    .done_o       (frame_done),
    .rslt_o       (rslt)
  );

  // result register
  logic            out_vld_q;
  mbrx_pkg::rslt_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && frame_done) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && frame_done) begin
      out_q <= rslt;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.is_broadcast;
  assign m_axis_tdata  = {5'd0,
                          out_q.flash_update_request,
                          out_q.error_code,
                          out_q.frame_length,
                          out_q.quantity_or_value,
                          out_q.start_address,
                          out_q.function_code};

  // a result only ever carries an accepted function code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.function_code == mbrx_pkg::CodeRead) ||
                  (out_q.function_code == mbrx_pkg::CodeWriteOne) ||
                  (out_q.function_code == mbrx_pkg::CodeWriteMany))
    else $error("result with unsupported function code");

  // flash request only on a clean multi-write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.flash_update_request) |->
      (out_q.error_code == mbrx_pkg::ERR_NONE) &&
      (out_q.function_code == mbrx_pkg::CodeWriteMany))
    else $error("flash request on a bad frame");

  // input stalls only behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_vld_q && out_vld_q && !m_axis_tready))
    else $error("input stalled without a held result");

  // a held result is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |=> out_vld_q && $stable(out_q))
    else $error("held result changed");

endmodule

>>> tb/modbus_rtu_slave_frame_receiver_tb.sv
`timescale 1ns / 1ps

module modbus_rtu_slave_frame_receiver_tb;

  // cycles without any accepted byte or result before the run is declared hung
  localparam int WatchdogLimit = 5000;
  // long sink hold-off, long enough to fill the block and stall its input
  localparam int HoldOffCycles = 300;
  // pipeline depth plus margin, waited before config writes and at the end
  localparam int SettleCycles  = 8;

  // one decoded frame as the block should report it
  typedef struct {
    logic [7:0]     func;
    logic           bcast;
    logic [15:0]    start;
    logic [15:0]    qty;
    logic [7:0]     len;
    mbrx_pkg::err_e err;
    logic           flash;
  } frame_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] function_code, [23:8] start_address, [39:24] quantity_or_value,
  // [47:40] frame_length, [49:48] error_code, [50] flash_update_request
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;        // [0] is_broadcast
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  modbus_rtu_slave_frame_receiver uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // frames the deframer still owes us, oldest first
  frame_result_t frames_due[$];
  int mismatches = 0;
  int bytes_sent = 0;

  // config mirror, reset values of the block
  logic [7:0]  cfg_slave = 8'd1;
  logic [15:0] cfg_flash = 16'd0;

  // receive tracker mirror
  int          rx_idx = 0;
  logic [7:0]  rx_func = mbrx_pkg::CodeRead;
  logic [15:0] rx_crc = mbrx_pkg::CrcInit;
  logic [15:0] rx_addr = '0;
  logic [15:0] rx_qty = '0;
  logic [7:0]  rx_count = '0;
  logic        rx_bcast = 1'b0;

  // idling switches, cleared for the last stretch of the run
  bit src_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;
  // hold-off requests from the test side, served by the sink process
  int hold_asked = 0;
  int hold_served = 0;

  // modbus crc-16, reflected, one byte lsb first
  function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc,
                                                  input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  // advance the frame tracker by one accepted byte, queue a result at frame end
  function automatic void deframe_byte(input logic [7:0] b);
    frame_result_t r;
    logic done;
    int idx;
    idx = rx_idx;
    // address byte: foreign addresses are simply dropped
    if (idx == mbrx_pkg::IdxSlave) begin
      if (b == cfg_slave || b == 8'h00) begin
        rx_bcast = (b == 8'h00);
        rx_crc = modbus_crc_byte(mbrx_pkg::CrcInit, b);
        rx_idx = mbrx_pkg::IdxFunc;
      end
      return;
    end
    // function byte: anything but 3, 6, 16 restarts reception
    if (idx == mbrx_pkg::IdxFunc) begin
      if (b == mbrx_pkg::CodeRead || b == mbrx_pkg::CodeWriteOne ||
          b == mbrx_pkg::CodeWriteMany) begin
        rx_func = b;
        rx_crc = modbus_crc_byte(rx_crc, b);
        rx_idx = mbrx_pkg::IdxAddrHi;
      end else begin
        rx_idx = 0;
        rx_crc = mbrx_pkg::CrcInit;
      end
      return;
    end
    rx_crc = modbus_crc_byte(rx_crc, b);
    case (idx)
      mbrx_pkg::IdxAddrHi: rx_addr[15:8] = b;
      mbrx_pkg::IdxAddrLo: rx_addr[7:0] = b;
      mbrx_pkg::IdxQtyHi:  rx_qty[15:8] = b;
      mbrx_pkg::IdxQtyLo:  rx_qty[7:0] = b;
      mbrx_pkg::IdxCount:  rx_count = b;
      default: ;
    endcase
    if (idx == mbrx_pkg::IdxAddrHi) begin
      rx_idx = mbrx_pkg::IdxAddrLo;
      return;
    end
    if (rx_func == mbrx_pkg::CodeWriteMany) begin
      done = (idx >= mbrx_pkg::ShortLast) && (idx == int'(rx_count) + mbrx_pkg::ManyExtra);
    end else begin
      done = (idx == mbrx_pkg::ShortLast);
    end
    if (!done) begin
      // index wrap drops the frame
      rx_idx = idx + 1;
      if (rx_idx >= mbrx_pkg::FrameMax) begin
        rx_idx = 0;
        rx_crc = mbrx_pkg::CrcInit;
      end
      return;
    end
    r.func = rx_func;
    r.bcast = rx_bcast;
    r.start = rx_addr;
    r.qty = rx_qty;
    r.len = (idx + 1 > 255) ? 8'd255 : 8'(idx + 1);
    r.flash = 1'b0;
    r.err = mbrx_pkg::ERR_NONE;
    if (rx_crc != 16'h0000) begin
      r.err = mbrx_pkg::ERR_CRC;
    end else if (rx_func == mbrx_pkg::CodeWriteMany) begin
      // a multi-write is only taken when it targets the flash register alone
      if (rx_addr == cfg_flash && rx_qty == 16'd1) begin
        r.flash = 1'b1;
      end else begin
        r.err = mbrx_pkg::ERR_CMD;
      end
    end
    frames_due.push_back(r);
    rx_idx = 0;
    rx_crc = mbrx_pkg::CrcInit;
  endfunction

  // offer one byte, optionally after a short gap, and wait for its handshake
  task automatic send_byte(input logic [7:0] b);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    deframe_byte(b);
  endtask

  // build a request with its crc; keep > 0 cuts it short after keep bytes
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] code,
                            input logic [15:0] start, input logic [15:0] qty,
                            input int ndata, input bit bad_crc, input int keep);
    logic [7:0] fb[$];
    logic [15:0] c;
    int n;
    fb.push_back(addr);
    fb.push_back(code);
    fb.push_back(start[15:8]);
    fb.push_back(start[7:0]);
    fb.push_back(qty[15:8]);
    fb.push_back(qty[7:0]);
    if (code == mbrx_pkg::CodeWriteMany) begin
      fb.push_back(8'(ndata));
      repeat (ndata) fb.push_back(8'($urandom_range(0, 255)));
    end
    c = mbrx_pkg::CrcInit;
    foreach (fb[i]) c = modbus_crc_byte(c, fb[i]);
    if (bad_crc) c ^= 16'($urandom_range(1, 65535));
    // crc goes out low byte first
    fb.push_back(c[7:0]);
    fb.push_back(c[15:8]);
    n = (keep == 0 || keep > fb.size()) ? fb.size() : keep;
    for (int i = 0; i < n; i++) send_byte(fb[i]);
  endtask

  // stop offering, wait for every result to come out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
  endtask

  // bring the tracker back to the address byte, drain, then settle
  task automatic quiesce();
    while (rx_idx != 0) send_byte(8'h00);
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // apb write: setup cycle, then access cycle; pready is always high
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == mbrx_pkg::AddrSlave) cfg_slave = data[7:0];
    else if (addr == mbrx_pkg::AddrFlash) cfg_flash = data[15:0];
  endtask

  task automatic set_config(input logic [7:0] slave, input logic [15:0] flash);
    quiesce();
    reg_write(mbrx_pkg::AddrSlave, {24'd0, slave});
    reg_write(mbrx_pkg::AddrFlash, {16'd0, flash});
  endtask

  // one random request, mostly well formed, the rest noise and broken frames
  task automatic random_frame();
    int pick;
    int ndata;
    logic [7:0] code;
    logic [7:0] b;
    logic [15:0] start;
    logic [15:0] qty;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0: code = mbrx_pkg::CodeRead;
      1: code = mbrx_pkg::CodeWriteOne;
      default: code = mbrx_pkg::CodeWriteMany;
    endcase
    start = 16'($urandom_range(0, 65535));
    qty = 16'($urandom_range(0, 65535));
    // multi-writes often aim at the flash register with a single register
    if (code == mbrx_pkg::CodeWriteMany && $urandom_range(0, 1) == 0) start = cfg_flash;
    if (code == mbrx_pkg::CodeWriteMany && $urandom_range(0, 1) == 0) qty = 16'd1;
    // mostly short payloads, now and then one up to the full byte count
    ndata = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
    b = ($urandom_range(0, 4) == 0) ? 8'h00 : cfg_slave;
    if (pick < 70) begin
      send_frame(b, code, start, qty, ndata, $urandom_range(0, 7) == 0, 0);
    end else if (pick < 80) begin
      // foreign station, whole frame goes past
      do b = 8'($urandom_range(1, 255)); while (b == cfg_slave);
      send_frame(b, code, start, qty, ndata, 1'b0, 0);
    end else if (pick < 88) begin
      // own station with an unsupported function code
      do code = 8'($urandom_range(0, 255));
      while (code == mbrx_pkg::CodeRead || code == mbrx_pkg::CodeWriteOne ||
             code == mbrx_pkg::CodeWriteMany);
      send_frame(b, code, start, qty, ndata, 1'b0, 0);
    end else if (pick < 95) begin
      // truncated request, the following bytes run into it
      send_frame(b, code, start, qty, ndata, 1'b0, $urandom_range(2, 7));
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_each_function();
    send_frame(cfg_slave, mbrx_pkg::CodeRead, 16'h1234, 16'h0002, 0, 1'b0, 0);
    send_frame(cfg_slave, mbrx_pkg::CodeWriteOne, 16'h00A5, 16'hBEEF, 0, 1'b0, 0);
    // flash hit, a multi-write to some other register and one to the flash with two registers
    send_frame(cfg_slave, mbrx_pkg::CodeWriteMany, cfg_flash, 16'd1, 2, 1'b0, 0);
    send_frame(cfg_slave, mbrx_pkg::CodeWriteMany, 16'h0040, 16'd3, 6, 1'b0, 0);
    send_frame(cfg_slave, mbrx_pkg::CodeWriteMany, cfg_flash, 16'd2, 4, 1'b0, 0);
    send_frame(8'h00, mbrx_pkg::CodeRead, 16'h0010, 16'h0001, 0, 1'b0, 0);
  endtask

  task automatic test_field_extremes();
    send_frame(cfg_slave, mbrx_pkg::CodeWriteOne, 16'hFFFF, 16'hFFFF, 0, 1'b0, 0);
    send_frame(8'h00, mbrx_pkg::CodeRead, 16'h0000, 16'h0000, 0, 1'b0, 0);
    send_frame(cfg_slave, mbrx_pkg::CodeWriteMany, 16'hFFFF, 16'd1, 0, 1'b0, 0);
  endtask

  task automatic test_crc_errors();
    send_frame(cfg_slave, mbrx_pkg::CodeRead, 16'h0100, 16'h0004, 0, 1'b1, 0);
    // flash target with a broken crc must not request an update
    send_frame(cfg_slave, mbrx_pkg::CodeWriteMany, cfg_flash, 16'd1, 2, 1'b1, 0);
  endtask

  task automatic test_foreign_and_bad_code();
    send_byte(8'hFF);
    send_byte(8'h7E);
    send_frame(cfg_slave, mbrx_pkg::CodeRead, 16'h0002, 16'h0001, 0, 1'b0, 0);
    // bad code equal to the own address is not a new frame start
    send_byte(cfg_slave);
    send_byte(cfg_slave);
    send_frame(cfg_slave, mbrx_pkg::CodeWriteOne, 16'h0003, 16'h5A5A, 0, 1'b0, 0);
  endtask

  task automatic test_long_frames();
    // 256 bytes: longest frame that completes, length saturates
    send_frame(cfg_slave, mbrx_pkg::CodeWriteMany, cfg_flash, 16'd1, 247, 1'b0, 0);
    // one more data byte and the index wraps before the end
    send_frame(cfg_slave, mbrx_pkg::CodeWriteMany, cfg_flash, 16'd1, 248, 1'b0, 0);
    quiesce();
  endtask

  task automatic test_address_register();
    set_config(8'd0, 16'hFFFF);
    send_frame(8'h00, mbrx_pkg::CodeWriteMany, 16'hFFFF, 16'd1, 1, 1'b0, 0);
    send_frame(8'h01, mbrx_pkg::CodeRead, 16'h0000, 16'd1, 0, 1'b0, 0);
    set_config(8'd247, 16'h0000);
    send_frame(8'd247, mbrx_pkg::CodeWriteMany, 16'h0000, 16'd1, 3, 1'b0, 0);
    send_frame(8'd1, mbrx_pkg::CodeRead, 16'h0000, 16'd1, 0, 1'b0, 0);
    set_config(8'd1, 16'h8001);
  endtask

  task automatic test_backpressure();
    // sink holds off while the requests keep coming
    hold_asked++;
    repeat (12) send_frame(cfg_slave, mbrx_pkg::CodeRead, 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)), 0, 1'b0, 0);
  endtask

  task automatic test_drain_pause();
    repeat (3) send_frame(cfg_slave, mbrx_pkg::CodeWriteOne, 16'h0007, 16'h0102, 0,
                          1'b0, 0);
    drain_results();
    repeat (3) send_frame(8'h00, mbrx_pkg::CodeWriteMany, cfg_flash, 16'd1, 1, 1'b0, 0);
  endtask

  task automatic test_random_traffic(input logic [7:0] slave, input logic [15:0] flash,
                                     input int nbytes, input bit idle);
    int stop_at;
    set_config(slave, flash);
    src_idle_en = idle;
    sink_idle_en = idle;
    stop_at = bytes_sent + nbytes;
    while (bytes_sent < stop_at) random_frame();
  endtask

  // sink side: long hold-offs on request, short random stalls otherwise
  int hold_left = 0;
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // result checker, one accepted result against the oldest frame due
  frame_result_t want;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (frames_due.size() == 0) begin
        $error("unexpected result: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = frames_due.pop_front();
        check_field("function_code", 16'(want.func), 16'(m_axis_tdata[7:0]));
        check_field("is_broadcast", 16'(want.bcast), 16'(m_axis_tuser));
        check_field("start_address", want.start, m_axis_tdata[23:8]);
        check_field("quantity_or_value", want.qty, m_axis_tdata[39:24]);
        check_field("frame_length", 16'(want.len), 16'(m_axis_tdata[47:40]));
        check_field("error_code", 16'(want.err), 16'(m_axis_tdata[49:48]));
        check_field("flash_update_request", 16'(want.flash), 16'(m_axis_tdata[50]));
      end
    end
  end

  // watchdog: no request moving on either side for too long means a hang
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_each_function();
    test_field_extremes();
    test_crc_errors();
    test_foreign_and_bad_code();
    test_long_frames();
    test_address_register();
    test_backpressure();
    test_drain_pause();

    // random phases over several register settings, last one without idling
    test_random_traffic(8'($urandom_range(2, 246)), 16'($urandom_range(0, 65535)),
                        100, 1'b1);
    test_random_traffic(8'd247, 16'hFFFF, 100, 1'b1);
    test_random_traffic(8'd1, 16'h0000, 100, 1'b1);
    test_random_traffic(8'($urandom_range(1, 247)), 16'($urandom_range(0, 65535)),
                        100, 1'b0);

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/mbrx_pkg.sv
rtl/mbrx_deframer.sv
rtl/modbus_rtu_slave_frame_receiver.sv
tb/modbus_rtu_slave_frame_receiver_tb.sv
